// ===== rtl/core/rqla_pkg.sv =====
// Shared types, constants and codes for the run-queue load averager.
// No dependencies; imported by the controller, the datapath and the top level.
package rqla_pkg;

    localparam int NUM_CPUS_DEF = 8;
    localparam int CPU_IDX_W    = 6;
    localparam int TIME_W       = 64;
    localparam int COUNT_W      = 16;
    localparam int AVG_W        = 31;
    localparam int PROD_W       = TIME_W + COUNT_W;
    localparam int DIV_STEPS    = AVG_W;
    localparam int DIV_CNT_W    = 5;

    localparam logic [COUNT_W-1:0] AVG_SCALE = 16'd100;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;
    localparam logic [AVG_W-1:0]   AVG_MAX   = 31'h7FFF_FFFF;

    localparam logic CMD_UPDATE = 1'b0;
    localparam logic CMD_QUERY  = 1'b1;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_LOAD,
        DP_READ,
        DP_ELAPSED,
        DP_MUL_LO,
        DP_MUL_HI,
        DP_MUL_SUM,
        DP_ACC_PROD,
        DP_WRITE,
        DP_DIV_INIT,
        DP_DIV_STEP,
        DP_RESULT
    } dp_op_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_READ,
        S_ELAPSED,
        S_MUL_LO,
        S_MUL_HI,
        S_MUL_SUM,
        S_ACC_PROD,
        S_WRITE,
        S_SC_LO,
        S_SC_HI,
        S_SC_SUM,
        S_DIV_INIT,
        S_DIV_STEP,
        S_RESULT
    } rqla_state_t;

    typedef struct packed {
        dp_op_t               op;
        logic [CPU_IDX_W-1:0] cpu;
        logic                 scale;   // multiplier runs 100 * total
        logic                 zero;    // result is zero (no time since last query)
    } dp_cmd_t;

    typedef struct packed {
        logic is_query;
        logic in_range;
        logic span_zero;
    } dp_status_t;

endpackage

// ===== rtl/core/rqla_ctrl.sv =====
// Sequencer for the run-queue load averager: walks CPUs, multiplies, divides.
// Depends on rqla_pkg; drives rqla_dp through dp_cmd_t and reads dp_status_t.
module rqla_ctrl #(
    parameter int NUM_CPUS = rqla_pkg::NUM_CPUS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  rqla_pkg::dp_status_t status,
    output rqla_pkg::dp_cmd_t    dp_cmd
);
    import rqla_pkg::*;

    localparam int CPU_W = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
    localparam logic [CPU_W-1:0] LAST_CPU = CPU_W'(NUM_CPUS - 1);

    rqla_state_t          state_reg, state_next;
    logic [CPU_W-1:0]     cpu_cnt_reg, cpu_cnt_next;
    logic [DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;
    logic                 zero_reg, zero_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cpu_cnt_reg   <= '0;
            div_cnt_reg   <= '0;
            zero_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cpu_cnt_reg   <= cpu_cnt_next;
            div_cnt_reg   <= div_cnt_next;
            zero_reg      <= zero_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // next state
    always_comb
    begin
        state_next     = state_reg;
        cpu_cnt_next   = cpu_cnt_reg;
        div_cnt_next   = div_cnt_reg;
        zero_next      = zero_reg;
        out_valid_next = out_ready ? 1'b0 : out_valid_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                    state_next = S_DECODE;
            end
            S_DECODE:
            begin
                if (!status.is_query && !status.in_range)
                    state_next = S_IDLE;
                else if (status.is_query && status.span_zero)
                begin
                    zero_next  = 1'b1;
                    state_next = S_RESULT;
                end
                else
                begin
                    zero_next    = 1'b0;
                    cpu_cnt_next = '0;
                    state_next   = S_READ;
                end
            end
            S_READ:     state_next = S_ELAPSED;
            S_ELAPSED:  state_next = S_MUL_LO;
            S_MUL_LO:   state_next = S_MUL_HI;
            S_MUL_HI:   state_next = S_MUL_SUM;
            S_MUL_SUM:  state_next = S_ACC_PROD;
            S_ACC_PROD: state_next = S_WRITE;
            S_WRITE:
            begin
                if (!status.is_query)
                    state_next = S_IDLE;
                else if (cpu_cnt_reg == LAST_CPU)
                    state_next = S_SC_LO;
                else
                begin
                    cpu_cnt_next = cpu_cnt_reg + 1'b1;
                    state_next   = S_READ;
                end
            end
            S_SC_LO:    state_next = S_SC_HI;
            S_SC_HI:    state_next = S_SC_SUM;
            S_SC_SUM:   state_next = S_DIV_INIT;
            S_DIV_INIT:
            begin
                div_cnt_next = '0;
                state_next   = S_DIV_STEP;
            end
            S_DIV_STEP:
            begin
                if (div_cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
                    state_next = S_RESULT;
                else
                    div_cnt_next = div_cnt_reg + 1'b1;
            end
            S_RESULT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:    state_next = S_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready     = 1'b0;
        dp_cmd.op    = DP_NOP;
        dp_cmd.cpu   = CPU_IDX_W'(cpu_cnt_reg);
        dp_cmd.scale = 1'b0;
        dp_cmd.zero  = zero_reg;
        case (state_reg)
            S_IDLE:
            begin
                in_ready  = 1'b1;
                dp_cmd.op = in_valid ? DP_LOAD : DP_NOP;
            end
            S_DECODE:   dp_cmd.op = DP_NOP;
            S_READ:     dp_cmd.op = DP_READ;
            S_ELAPSED:  dp_cmd.op = DP_ELAPSED;
            S_MUL_LO:   dp_cmd.op = DP_MUL_LO;
            S_MUL_HI:   dp_cmd.op = DP_MUL_HI;
            S_MUL_SUM:  dp_cmd.op = DP_MUL_SUM;
            S_ACC_PROD: dp_cmd.op = DP_ACC_PROD;
            S_WRITE:    dp_cmd.op = DP_WRITE;
            S_SC_LO:
            begin
                dp_cmd.op    = DP_MUL_LO;
                dp_cmd.scale = 1'b1;
            end
            S_SC_HI:
            begin
                dp_cmd.op    = DP_MUL_HI;
                dp_cmd.scale = 1'b1;
            end
            S_SC_SUM:
            begin
                dp_cmd.op    = DP_MUL_SUM;
                dp_cmd.scale = 1'b1;
            end
            S_DIV_INIT: dp_cmd.op = DP_DIV_INIT;
            S_DIV_STEP: dp_cmd.op = DP_DIV_STEP;
            S_RESULT:   dp_cmd.op = out_free ? DP_RESULT : DP_NOP;
            default:    dp_cmd.op = DP_NOP;
        endcase
    end

    a_result_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RESULT && !out_free) |=> (state_reg == S_RESULT))
        else $error("result dropped while output word still pending");

    a_result_shows: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RESULT && out_free) |=> out_valid_reg)
        else $error("loaded result not presented");

    a_div_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV_STEP) |-> (div_cnt_reg < DIV_CNT_W'(DIV_STEPS)))
        else $error("divider step count overran");

    a_cpu_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cpu_cnt_reg <= LAST_CPU)
        else $error("CPU walk past last entry");

    a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && !in_valid) |=> (state_reg == S_IDLE))
        else $error("left idle without an input word");

endmodule

// ===== rtl/core/rqla_dp.sv =====
// Datapath of the run-queue load averager: per-CPU row memory, two multiply
// lanes (run, iowait), accumulators and two restoring dividers. Uses rqla_pkg.
module rqla_dp #(
    parameter int NUM_CPUS = rqla_pkg::NUM_CPUS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  rqla_pkg::dp_cmd_t                 dp_cmd,
    output rqla_pkg::dp_status_t              status,
    input  logic                              cmd,
    input  logic [rqla_pkg::CPU_IDX_W-1:0]    cpu_index,
    input  logic [rqla_pkg::TIME_W-1:0]       time_now,
    input  logic [rqla_pkg::COUNT_W-1:0]      runnable_count,
    input  logic                              increment,
    input  logic [rqla_pkg::COUNT_W-1:0]      iowait_tasks,
    output logic [rqla_pkg::AVG_W-1:0]        run_average,
    output logic [rqla_pkg::AVG_W-1:0]        iowait_average
);
    import rqla_pkg::*;

    localparam int CPU_W = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
    localparam int HALF  = TIME_W / 2;
    localparam int PP_W  = COUNT_W + HALF;
    localparam int HI_W  = PROD_W - AVG_W;

    typedef struct packed {
        logic [TIME_W-1:0]  run_sum;
        logic [TIME_W-1:0]  io_sum;
        logic [TIME_W-1:0]  lct;
        logic [COUNT_W-1:0] count;
        logic [COUNT_W-1:0] iowait;
    } row_t;

    function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                  input logic [TIME_W-1:0] b);
        logic [TIME_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TIME_W] ? '1 : s[TIME_W-1:0];
    endfunction

    function automatic logic [TIME_W-1:0] sat_prod(input logic [PROD_W-1:0] p);
        return (|p[PROD_W-1:TIME_W]) ? '1 : p[TIME_W-1:0];
    endfunction

    // latched input word
    logic                 cmd_reg;
    logic [CPU_IDX_W-1:0] cpu_reg;
    logic [TIME_W-1:0]    now_reg;
    logic [COUNT_W-1:0]   runnable_reg;
    logic                 inc_reg;
    logic [COUNT_W-1:0]   iowait_reg;

    logic [TIME_W-1:0]    lqt_reg;
    logic [TIME_W-1:0]    span_reg;

    row_t                 mem [NUM_CPUS];
    logic [NUM_CPUS-1:0]  row_valid_reg;
    row_t                 rd_row_reg;
    logic                 rd_valid_reg;
    row_t                 row;
    row_t                 wr_row;
    logic [CPU_W-1:0]     addr;
    logic                 is_query;
    logic [COUNT_W-1:0]   new_count;

    logic [TIME_W-1:0]    elapsed_reg;
    logic [TIME_W-1:0]    acc_reg   [2];
    logic [PP_W-1:0]      p_lo_reg  [2];
    logic [PP_W-1:0]      p_hi_reg  [2];
    logic [PROD_W-1:0]    prod_reg  [2];
    logic [TIME_W-1:0]    rem_reg   [2];
    logic [AVG_W-1:0]     q_reg     [2];
    logic                 ovf_reg   [2];
    logic [AVG_W-1:0]     avg_reg   [2];

    logic [COUNT_W-1:0]   mul_a     [2];
    logic [TIME_W-1:0]    mul_b     [2];
    logic [HI_W-1:0]      num_hi    [2];
    logic                 num_ovf   [2];
    logic [TIME_W:0]      trial     [2];
    logic                 trial_ge  [2];
    logic [TIME_W:0]      trial_sub [2];

    assign is_query = (cmd_reg == CMD_QUERY);
    assign addr     = is_query ? dp_cmd.cpu[CPU_W-1:0] : cpu_reg[CPU_W-1:0];
    assign row      = rd_valid_reg ? rd_row_reg : '0;

    assign status.is_query  = is_query;
    assign status.in_range  = ({1'b0, cpu_reg} < (CPU_IDX_W + 1)'(NUM_CPUS));
    assign status.span_zero = (span_reg == '0);

    always_comb
    begin
        if (inc_reg)
            new_count = (runnable_reg == COUNT_MAX) ? COUNT_MAX : runnable_reg + 1'b1;
        else
            new_count = (runnable_reg == '0) ? '0 : runnable_reg - 1'b1;
    end

    always_comb
    begin
        wr_row.lct = now_reg;
        if (is_query)
        begin
            wr_row.run_sum = '0;
            wr_row.io_sum  = '0;
            wr_row.count   = row.count;
            wr_row.iowait  = row.iowait;
        end
        else
        begin
            wr_row.run_sum = acc_reg[0];
            wr_row.io_sum  = acc_reg[1];
            wr_row.count   = new_count;
            wr_row.iowait  = iowait_reg;
        end
    end

    // operands and divider step per lane (0 = run, 1 = iowait)
    always_comb
    begin
        mul_a[0] = dp_cmd.scale ? AVG_SCALE : (is_query ? row.count : runnable_reg);
        mul_a[1] = dp_cmd.scale ? AVG_SCALE : (is_query ? row.iowait : iowait_reg);
        for (int l = 0; l < 2; l++)
        begin
            mul_b[l]     = dp_cmd.scale ? acc_reg[l] : elapsed_reg;
            num_hi[l]    = prod_reg[l][PROD_W-1:AVG_W];
            // quotient would reach 2^31 exactly when numerator >> 31 >= span
            num_ovf[l]   = (TIME_W'(num_hi[l]) >= span_reg);
            trial[l]     = {rem_reg[l], q_reg[l][AVG_W-1]};
            trial_ge[l]  = (trial[l] >= {1'b0, span_reg});
            trial_sub[l] = trial[l] - {1'b0, span_reg};
        end
    end

    // row memory
    always_ff @(posedge clk)
    begin
        if (dp_cmd.op == DP_WRITE)
            mem[addr] <= wr_row;
        if (dp_cmd.op == DP_READ)
            rd_row_reg <= mem[addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
            lqt_reg       <= '0;
        end
        else
        begin
            if (dp_cmd.op == DP_WRITE)
                row_valid_reg[addr] <= 1'b1;
            if (dp_cmd.op == DP_READ)
                rd_valid_reg <= row_valid_reg[addr];
            if (dp_cmd.op == DP_LOAD && cmd == CMD_QUERY && time_now != lqt_reg)
                lqt_reg <= time_now;
        end
    end

    always_ff @(posedge clk)
    begin
        case (dp_cmd.op)
            DP_LOAD:
            begin
                cmd_reg      <= cmd;
                cpu_reg      <= cpu_index;
                now_reg      <= time_now;
                runnable_reg <= runnable_count;
                inc_reg      <= increment;
                iowait_reg   <= iowait_tasks;
                span_reg     <= time_now - lqt_reg;
                acc_reg[0]   <= '0;
                acc_reg[1]   <= '0;
            end
            DP_ELAPSED:
            begin
                elapsed_reg <= now_reg - row.lct;
                acc_reg[0]  <= sat_add(acc_reg[0], row.run_sum);
                acc_reg[1]  <= sat_add(acc_reg[1], row.io_sum);
            end
            DP_MUL_LO:
            begin
                for (int l = 0; l < 2; l++)
                    p_lo_reg[l] <= PP_W'(mul_a[l]) * PP_W'(mul_b[l][HALF-1:0]);
            end
            DP_MUL_HI:
            begin
                for (int l = 0; l < 2; l++)
                    p_hi_reg[l] <= PP_W'(mul_a[l]) * PP_W'(mul_b[l][TIME_W-1:HALF]);
            end
            DP_MUL_SUM:
            begin
                for (int l = 0; l < 2; l++)
                    prod_reg[l] <= {p_hi_reg[l], HALF'(0)} + PROD_W'(p_lo_reg[l]);
            end
            DP_ACC_PROD:
            begin
                for (int l = 0; l < 2; l++)
                    acc_reg[l] <= sat_add(acc_reg[l], sat_prod(prod_reg[l]));
            end
            DP_DIV_INIT:
            begin
                for (int l = 0; l < 2; l++)
                begin
                    ovf_reg[l] <= num_ovf[l];
                    rem_reg[l] <= num_ovf[l] ? '0 : TIME_W'(num_hi[l]);
                    q_reg[l]   <= prod_reg[l][AVG_W-1:0];
                end
            end
            DP_DIV_STEP:
            begin
                // numerator bits shift out of q at the top, quotient bits in at the bottom
                for (int l = 0; l < 2; l++)
                begin
                    rem_reg[l] <= trial_ge[l] ? trial_sub[l][TIME_W-1:0]
                                              : trial[l][TIME_W-1:0];
                    q_reg[l]   <= {q_reg[l][AVG_W-2:0], trial_ge[l]};
                end
            end
            DP_RESULT:
            begin
                for (int l = 0; l < 2; l++)
                    avg_reg[l] <= dp_cmd.zero ? '0 : (ovf_reg[l] ? AVG_MAX : q_reg[l]);
            end
            default:
            begin
            end
        endcase
    end

    assign run_average    = avg_reg[0];
    assign iowait_average = avg_reg[1];

endmodule

// ===== rtl/core/run_queue_load_averager_top.sv =====
// Run-queue load averager. An update word (cmd 0) updates the row of one
// CPU; a query word (cmd 1) walks every CPU and divides, or gives zero
// averages when no time has passed since the last query. The query cost
// is set by the walk over the per-CPU row memory (one shared 16x32 multiply
// pair, used for each CPU in turn, two halves per 64-bit product) and by
// the two restoring dividers that retire one quotient bit per cycle. One
// word is worked on at a time; a finished result sits in the output
// register while the next word is accepted.
// Depends on rqla_pkg, rqla_ctrl and rqla_dp.
module run_queue_load_averager_top #(
    parameter int NUM_CPUS = rqla_pkg::NUM_CPUS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              cmd,
    input  logic [rqla_pkg::CPU_IDX_W-1:0]    cpu_index,
    input  logic [rqla_pkg::TIME_W-1:0]       time_now,
    input  logic [rqla_pkg::COUNT_W-1:0]      runnable_count,
    input  logic                              increment,
    input  logic [rqla_pkg::COUNT_W-1:0]      iowait_tasks,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [rqla_pkg::AVG_W-1:0]        run_average,
    output logic [rqla_pkg::AVG_W-1:0]        iowait_average
);
    import rqla_pkg::*;

    dp_cmd_t    dp_cmd;
    dp_status_t status;

    rqla_ctrl #(
        .NUM_CPUS (NUM_CPUS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .dp_cmd    (dp_cmd)
    );

    rqla_dp #(
        .NUM_CPUS (NUM_CPUS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .dp_cmd         (dp_cmd),
        .status         (status),
        .cmd            (cmd),
        .cpu_index      (cpu_index),
        .time_now       (time_now),
        .runnable_count (runnable_count),
        .increment      (increment),
        .iowait_tasks   (iowait_tasks),
        .run_average    (run_average),
        .iowait_average (iowait_average)
    );

endmodule

// ===== sim/tb.sv =====
// Testbench for run_queue_load_averager_top: directed table, then random update/query words.
// Results are checked against an in-bench predictor of the per-CPU load sums.
// Depends on rqla_pkg and run_queue_load_averager_top.
`timescale 1ns / 1ps

module tb;
    import rqla_pkg::*;

    localparam int CPUS       = NUM_CPUS_DEF;
    localparam int RAND_WORDS = 650;
    localparam int TAIL_START = 570;

    typedef struct {
        logic               cmd;
        logic [5:0]         cpu;
        logic [63:0]        tm;
        logic [15:0]        runc;
        logic               inc;
        logic [15:0]        iow;
        bit                 typed;    // expectation below is fixed by hand
        logic [AVG_W-1:0]   t_run;
        logic [AVG_W-1:0]   t_io;
    } load_word_t;

    typedef struct {
        logic [AVG_W-1:0] run;
        logic [AVG_W-1:0] io;
    } avg_pair_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic                 cmd;
    logic [CPU_IDX_W-1:0] cpu_index;
    logic [TIME_W-1:0]    time_now;
    logic [COUNT_W-1:0]   runnable_count;
    logic                 increment;
    logic [COUNT_W-1:0]   iowait_tasks;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [AVG_W-1:0]     run_average;
    logic [AVG_W-1:0]     iowait_average;

    // predictor state
    logic [63:0] run_sum  [CPUS];
    logic [63:0] io_sum   [CPUS];
    logic [63:0] last_chg [CPUS];
    logic [15:0] cur_cnt  [CPUS];
    logic [15:0] cur_io   [CPUS];
    logic [63:0] last_qry;

    avg_pair_t   avg_expect_q[$];
    load_word_t  dir_rows[$];
    logic [63:0] clock_ns;
    int          errors = 0;
    int          gap_pct = 30;
    bit          tail_phase = 1'b0;
    int          out_hold = 0;
    int unsigned cyc = 0;

    run_queue_load_averager_top #(.NUM_CPUS(CPUS)) i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .cmd            (cmd),
        .cpu_index      (cpu_index),
        .time_now       (time_now),
        .runnable_count (runnable_count),
        .increment      (increment),
        .iowait_tasks   (iowait_tasks),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .run_average    (run_average),
        .iowait_average (iowait_average)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [63:0] sat_add64(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? '1 : s[63:0];
    endfunction

    function automatic logic [63:0] sat_mul64(input logic [15:0] cnt, input logic [63:0] dt);
        logic [79:0] p;
        p = {64'b0, cnt} * {16'b0, dt};
        return (p[79:64] != 16'b0) ? '1 : p[63:0];
    endfunction

    // floor(total * 100 / span), clamped; span is nonzero
    function automatic logic [AVG_W-1:0] scaled_avg(input logic [63:0] total,
                                                    input logic [63:0] span);
        logic [127:0] q;
        q = ({64'b0, total} * {112'b0, AVG_SCALE}) / {64'b0, span};
        return (q > {97'b0, AVG_MAX}) ? AVG_MAX : q[AVG_W-1:0];
    endfunction

    task automatic apply_load_word(input load_word_t w);
        logic [63:0] dt;
        logic [63:0] span;
        logic [63:0] run_tot;
        logic [63:0] io_tot;
        avg_pair_t   res;
        int          c;
        run_tot = '0;
        io_tot  = '0;
        if (w.cmd == CMD_UPDATE)
        begin
            if (w.cpu < CPUS)
            begin
                dt = w.tm - last_chg[w.cpu];
                last_chg[w.cpu] = w.tm;
                run_sum[w.cpu] = sat_add64(run_sum[w.cpu], sat_mul64(w.runc, dt));
                io_sum[w.cpu]  = sat_add64(io_sum[w.cpu], sat_mul64(w.iow, dt));
                if (w.inc)
                    cur_cnt[w.cpu] = (w.runc == COUNT_MAX) ? COUNT_MAX : w.runc + 16'd1;
                else
                    cur_cnt[w.cpu] = (w.runc == 16'd0) ? 16'd0 : w.runc - 16'd1;
                cur_io[w.cpu] = w.iow;
            end
        end
        else
        begin
            span = w.tm - last_qry;
            res.run = '0;
            res.io  = '0;
            if (span != 64'd0)
            begin
                last_qry = w.tm;
                for (c = 0; c < CPUS; c++)
                begin
                    dt      = w.tm - last_chg[c];
                    run_tot = sat_add64(run_tot, run_sum[c]);
                    run_tot = sat_add64(run_tot, sat_mul64(cur_cnt[c], dt));
                    io_tot  = sat_add64(io_tot, io_sum[c]);
                    io_tot  = sat_add64(io_tot, sat_mul64(cur_io[c], dt));
                    last_chg[c] = w.tm;
                    run_sum[c]  = '0;
                    io_sum[c]   = '0;
                end
                res.run = scaled_avg(run_tot, span);
                res.io  = scaled_avg(io_tot, span);
            end
            if (w.typed)
            begin
                res.run = w.t_run;
                res.io  = w.t_io;
            end
            avg_expect_q.push_back(res);
        end
    endtask

    function automatic load_word_t row(input logic c, input logic [5:0] cpu,
                                       input logic [63:0] tm, input logic [15:0] rc,
                                       input logic ic, input logic [15:0] iw,
                                       input bit typed, input logic [AVG_W-1:0] tr,
                                       input logic [AVG_W-1:0] ti);
        load_word_t w;
        w.cmd = c;  w.cpu = cpu;  w.tm = tm;  w.runc = rc;  w.inc = ic;  w.iow = iw;
        w.typed = typed;  w.t_run = tr;  w.t_io = ti;
        return w;
    endfunction

    // mostly realistic scheduler traffic: counts follow the predicted count, time advances
    task automatic make_word(output load_word_t w);
        int kind;
        int pick;
        kind = $urandom_range(0, 99);
        w = row(CMD_UPDATE, 6'd0, 64'd0, 16'd0, 1'b0, 16'd0, 1'b0, '0, '0);
        if (kind < 12)
        begin
            w.cmd  = CMD_QUERY;
            w.cpu  = 6'($urandom_range(0, 63));
            w.runc = 16'($urandom);
            w.inc  = 1'($urandom_range(0, 1));
            w.iow  = 16'($urandom);
            pick   = $urandom_range(0, 9);
            if (pick == 0)
                w.tm = last_qry;
            else if (pick == 1)
                w.tm = {$urandom, $urandom};
            else
            begin
                clock_ns = clock_ns + $urandom_range(1, 20000);
                w.tm = clock_ns;
            end
        end
        else if (kind < 82)
        begin
            w.cpu    = 6'($urandom_range(0, CPUS - 1));
            clock_ns = clock_ns + $urandom_range(0, 5000);
            w.tm     = clock_ns;
            w.runc   = cur_cnt[w.cpu];
            w.inc    = (cur_cnt[w.cpu] == 16'd0) ? 1'b1 : 1'($urandom_range(0, 1));
            w.iow    = 16'($urandom_range(0, 12));
        end
        else
        begin
            w.cpu  = 6'($urandom_range(0, 63));
            w.tm   = ($urandom_range(0, 2) == 0) ? {$urandom, $urandom}
                                                  : clock_ns + $urandom_range(0, 3000);
            w.runc = 16'($urandom);
            w.inc  = 1'($urandom_range(0, 1));
            w.iow  = 16'($urandom);
        end
    endtask

    task automatic idle_gap();
        if (!tail_phase && $urandom_range(0, 99) < gap_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
    endtask

    task automatic send_word(input load_word_t w);
        in_valid       <= 1'b1;
        cmd            <= w.cmd;
        cpu_index      <= w.cpu;
        time_now       <= w.tm;
        runnable_count <= w.runc;
        increment      <= w.inc;
        iowait_tasks   <= w.iow;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        apply_load_word(w);
    endtask

    // result side: random stall bursts, quiet windows, none in the tail
    always @(posedge clk)
    begin
        cyc <= cyc + 1;
        if (tail_phase || cyc[9:8] == 2'b11)
        begin
            out_hold = 0;
            out_ready <= 1'b1;
        end
        else if (out_hold > 0)
        begin
            out_hold = out_hold - 1;
            out_ready <= 1'b0;
        end
        else if ($urandom_range(0, 5) == 0)
        begin
            out_hold = $urandom_range(0, 6);
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    always @(posedge clk)
    begin : result_check
        avg_pair_t exp_pair;
        if (rst_n && out_valid && out_ready)
        begin
            if (avg_expect_q.size() == 0)
            begin
                $display("%0t: unexpected result run_average %0d iowait_average %0d",
                         $time, run_average, iowait_average);
                errors++;
            end
            else
            begin
                exp_pair = avg_expect_q.pop_front();
                if (run_average !== exp_pair.run)
                begin
                    $display("%0t: run_average expected %0d actual %0d",
                             $time, exp_pair.run, run_average);
                    errors++;
                end
                if (iowait_average !== exp_pair.io)
                begin
                    $display("%0t: iowait_average expected %0d actual %0d",
                             $time, exp_pair.io, iowait_average);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        load_word_t w;
        int         n_items;
        int         i;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        cmd            = CMD_UPDATE;
        cpu_index      = '0;
        time_now       = '0;
        runnable_count = '0;
        increment      = 1'b0;
        iowait_tasks   = '0;
        for (i = 0; i < CPUS; i++)
        begin
            run_sum[i] = '0;  io_sum[i] = '0;  last_chg[i] = '0;
            cur_cnt[i] = '0;  cur_io[i] = '0;
        end
        last_qry = '0;

        // cmd, cpu, time, runnable, inc, iowait, typed, run, iowait
        dir_rows.push_back(row(CMD_QUERY,  6'd0,  64'd0,    16'd0,     1'b0, 16'd0,
                               1'b1, '0, '0));                  // no time since reset
        dir_rows.push_back(row(CMD_QUERY,  6'd63, 64'd1000, 16'hFFFF,  1'b1, 16'hFFFF,
                               1'b1, '0, '0));                  // all counts zero
        dir_rows.push_back(row(CMD_UPDATE, 6'd0,  64'd1000, 16'd0,     1'b1, 16'd0,
                               1'b0, '0, '0));
        dir_rows.push_back(row(CMD_UPDATE, 6'd7,  64'd1000, COUNT_MAX, 1'b1, 16'hFFFF,
                               1'b0, '0, '0));                  // rise clamps at max
        dir_rows.push_back(row(CMD_UPDATE, 6'd1,  64'd1500, 16'd0,     1'b0, 16'd3,
                               1'b0, '0, '0));                  // fall clamps at zero
        dir_rows.push_back(row(CMD_UPDATE, 6'd8,  64'd1700, 16'd9,     1'b1, 16'd9,
                               1'b0, '0, '0));                  // cpu out of range
        dir_rows.push_back(row(CMD_UPDATE, 6'd63, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF, 1'b0,
                               16'hFFFF, 1'b0, '0, '0));
        dir_rows.push_back(row(CMD_QUERY,  6'd0,  64'd2000, 16'd0,     1'b0, 16'd0,
                               1'b0, '0, '0));
        dir_rows.push_back(row(CMD_QUERY,  6'd0,  64'd2000, 16'd0,     1'b0, 16'd0,
                               1'b1, '0, '0));                  // repeat query, zero span
        dir_rows.push_back(row(CMD_UPDATE, 6'd2,  64'd0,    COUNT_MAX, 1'b0, 16'hFFFF,
                               1'b0, '0, '0));                  // time backwards, sums clamp
        dir_rows.push_back(row(CMD_QUERY,  6'd0,  64'd2001, 16'd0,     1'b0, 16'd0,
                               1'b1, AVG_MAX, AVG_MAX));        // averages clamp
        dir_rows.push_back(row(CMD_QUERY,  6'd0,  64'hFFFF_FFFF_FFFF_FFFF, 16'd0, 1'b0, 16'd0,
                               1'b0, '0, '0));
        dir_rows.push_back(row(CMD_UPDATE, 6'd3,  64'hFFFF_FFFF_FFFF_FFFF, 16'h5555, 1'b1,
                               16'hAAAA, 1'b0, '0, '0));
        dir_rows.push_back(row(CMD_UPDATE, 6'd3,  64'd0,    16'hAAAA,  1'b0, 16'h5555,
                               1'b0, '0, '0));                  // elapsed wraps to one
        dir_rows.push_back(row(CMD_UPDATE, 6'd5,  64'd0,    16'd40,    1'b1, 16'd7,
                               1'b0, '0, '0));
        dir_rows.push_back(row(CMD_QUERY,  6'd0,  64'd0,    16'd0,     1'b0, 16'd0,
                               1'b0, '0, '0));                  // span wraps to one
        dir_rows.push_back(row(CMD_UPDATE, 6'd6,  64'h8000_0000_0000_0000, 16'd3, 1'b1,
                               16'd2, 1'b0, '0, '0));
        dir_rows.push_back(row(CMD_QUERY,  6'd0,  64'h8000_0000_0000_4000, 16'd0, 1'b0, 16'd0,
                               1'b0, '0, '0));
        dir_rows.push_back(row(CMD_QUERY,  6'd0,  64'h0000_0001_0000_0000, 16'd0, 1'b0, 16'd0,
                               1'b0, '0, '0));

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            idle_gap();
            send_word(dir_rows[i]);
        end

        clock_ns = 64'h0000_0001_0000_0000;
        n_items  = 0;
        while (n_items < RAND_WORDS)
        begin
            tail_phase = (n_items >= TAIL_START);
            make_word(w);
            idle_gap();
            send_word(w);
            n_items++;
            if (n_items % 40 == 0)
                gap_pct = 25 * $urandom_range(0, 2);
        end
        tail_phase = 1'b1;
        in_valid <= 1'b0;

        while (avg_expect_q.size() != 0) @(posedge clk);
        repeat (120) @(posedge clk);
        if (errors == 0 && avg_expect_q.size() == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("tb NOT OK");
        $finish;
    end

endmodule
